FILE: design/mrmf_pkg.sv
`timescale 1ns / 1ps
package mrmf_pkg;
    localparam int MAX_RINGS  = 8;
    localparam int RING_BYTES = 4096;
    localparam int RW   = $clog2(MAX_RINGS);
    localparam int OW   = $clog2(RING_BYTES);
    localparam int AW   = RW + OW;
    localparam int SZW  = OW + 1;

    localparam logic [2:0] OP_SEND_BEGIN = 3'd0;
    localparam logic [2:0] OP_SEND_BYTE  = 3'd1;
    localparam logic [2:0] OP_RECV_BEGIN = 3'd2;
    localparam logic [2:0] OP_RECV_BYTE  = 3'd3;
    localparam logic [2:0] OP_PEER_PUT   = 3'd4;
    localparam logic [2:0] OP_PEER_GET   = 3'd5;
    localparam logic [2:0] OP_POLL       = 3'd6;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_EMPTY   = 3'd1;
    localparam logic [2:0] ST_LONG    = 3'd2;
    localparam logic [2:0] ST_ROOM    = 3'd3;
    localparam logic [2:0] ST_OVERRUN = 3'd4;
    localparam logic [2:0] ST_BADRING = 3'd5;
    localparam logic [2:0] ST_NOXFER  = 3'd6;

    localparam logic [1:0] REG_TX_SIZE   = 2'd0;
    localparam logic [1:0] REG_RX_SIZE   = 2'd1;
    localparam logic [1:0] REG_NUM_RINGS = 2'd2;

    typedef struct packed {
        logic [2:0]  op;
        logic [2:0]  ring;
        logic [12:0] length;
        logic [7:0]  data;
    } t_in;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  byte_out;
        logic [12:0] count;
        logic        last;
        logic        write_event;
        logic        read_event;
        logic        writable;
    } t_out;

    // Controller to datapath.
    typedef struct packed {
        logic eval;
        logic mem_rd;
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic needs_read;
    } t_stat;
endpackage

FILE: design/multi_ring_message_fifo.sv
`timescale 1ns / 1ps
// Multi-ring message FIFO with up to eight transmit/receive ring pairs of bytes.
// Each beat produces exactly one result beat. Receive byte and peer get pass
// through an extra read state for the registered read of the ring storage
// memory; one beat is in flight at a time, and the next beat is taken no
// earlier than the cycle in which the previous result leaves the output
// register.
module multi_ring_message_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [1:0]      i_cfg_index,
    input  logic [12:0]     i_cfg_data,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  mrmf_pkg::t_in   i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output mrmf_pkg::t_out  o_out_data
);
    mrmf_pkg::t_cmd  cmd;
    mrmf_pkg::t_stat stat;

    mrmf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    mrmf_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_load      (i_in_valid && o_in_ready),
        .i_item      (i_in_data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_result    (o_out_data)
    );

`ifndef SYNTH
    // A result is valid in the cycle after the evaluate step.
    a_eval_to_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.eval |=> o_out_valid) else $error("result not presented after eval");
    // No beat is taken while a result is stuck at the output.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("input accepted over a stalled result");
    // An accepted beat that needs no memory read goes straight to the evaluate state.
    a_accept_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && !stat.needs_read) |=> cmd.eval)
        else $error("beat not evaluated");
`endif
endmodule

FILE: design/mrmf_ctrl.sv
`timescale 1ns / 1ps
module mrmf_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    input  mrmf_pkg::t_stat      i_stat,
    output mrmf_pkg::t_cmd       o_cmd
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_EVAL = 2'd2;

    logic [1:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       acc;

    // A new beat may enter when the controller is idle and the output slot is empty or draining.
    assign o_in_ready  = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign acc = i_in_valid && o_in_ready;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    o_cmd.mem_rd = 1'b1;
                    n_state = i_stat.needs_read ? S_READ : S_EVAL;
                end
            end
            S_READ: begin
                n_state = S_EVAL;
            end
            S_EVAL: begin
                o_cmd.eval  = 1'b1;
                n_out_valid = 1'b1;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end
endmodule

FILE: design/mrmf_dp.sv
`timescale 1ns / 1ps
module mrmf_dp (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [1:0]      i_cfg_index,
    input  logic [12:0]     i_cfg_data,
    input  logic            i_load,
    input  mrmf_pkg::t_in   i_item,
    input  mrmf_pkg::t_cmd  i_cmd,
    output mrmf_pkg::t_stat o_stat,
    output mrmf_pkg::t_out  o_result
);
    localparam int RW  = mrmf_pkg::RW;
    localparam int OW  = mrmf_pkg::OW;
    localparam int AW  = mrmf_pkg::AW;
    localparam int SZW = mrmf_pkg::SZW;
    localparam int NR  = mrmf_pkg::MAX_RINGS;

    logic [12:0] r_tx_size, r_rx_size;
    logic [3:0]  r_num_rings;

    logic [7:0] tx_mem [0:(1<<AW)-1];
    logic [7:0] rx_mem [0:(1<<AW)-1];
    logic [7:0] r_tx_rd, r_rx_rd;

    logic [31:0]   r_txw [0:NR-1];
    logic [31:0]   r_txr [0:NR-1];
    logic [31:0]   r_rxw [0:NR-1];
    logic [31:0]   r_rxr [0:NR-1];
    logic [OW-1:0] r_txwo [0:NR-1];
    logic [OW-1:0] r_txro [0:NR-1];
    logic [OW-1:0] r_rxwo [0:NR-1];
    logic [OW-1:0] r_rxro [0:NR-1];

    logic [1:0]    r_mode;
    logic [RW-1:0] r_oring;
    logic [12:0]   r_left;
    logic [OW-1:0] r_cursor;
    logic [12:0]   r_total;

    mrmf_pkg::t_in  r_item;
    mrmf_pkg::t_out r_res;
    mrmf_pkg::t_out n_res;

    localparam logic [1:0] M_NONE = 2'd0;
    localparam logic [1:0] M_SEND = 2'd1;
    localparam logic [1:0] M_RECV = 2'd2;

    logic [SZW-1:0] tsz, rsz;
    logic [3:0]     nrings;

    always_comb begin
        tsz = (r_tx_size == 13'd0) ? SZW'(1)
            : (r_tx_size > 13'(mrmf_pkg::RING_BYTES)) ? SZW'(mrmf_pkg::RING_BYTES)
            : SZW'(r_tx_size);
        rsz = (r_rx_size == 13'd0) ? SZW'(1)
            : (r_rx_size > 13'(mrmf_pkg::RING_BYTES)) ? SZW'(mrmf_pkg::RING_BYTES)
            : SZW'(r_rx_size);
        nrings = (r_num_rings == 4'd0) ? 4'd1
               : (r_num_rings > 4'(NR)) ? 4'(NR) : r_num_rings;
    end

    // Addresses for the memory read: transmit from the beat as it enters, receive from the open transfer.
    logic [RW-1:0] in_ring;
    logic [AW-1:0] rd_tx_addr, rd_rx_addr;
    assign in_ring = i_item.ring[RW-1:0];
    assign rd_tx_addr = {in_ring, r_txro[in_ring]};
    assign rd_rx_addr = {r_oring, r_cursor};
    assign o_stat.needs_read = (i_item.op == mrmf_pkg::OP_PEER_GET)
                            || (i_item.op == mrmf_pkg::OP_RECV_BYTE);

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_rd) begin
            r_tx_rd <= tx_mem[rd_tx_addr];
            r_rx_rd <= rx_mem[rd_rx_addr];
        end
        if (i_load) begin
            r_item <= i_item;
        end
    end

    function automatic logic [OW-1:0] adv(input logic [OW-1:0] off,
                                          input logic [SZW-1:0] sz);
        logic [SZW-1:0] nx;
        nx = SZW'(off) + SZW'(1);
        return (nx >= sz) ? '0 : nx[OW-1:0];
    endfunction

    logic [RW-1:0] q;
    logic          bad;
    logic [31:0]   tx_used, rx_pend, rx_since;
    logic [32:0]   room;
    assign q        = r_item.ring[RW-1:0];
    assign bad      = ({1'b0, r_item.ring} >= nrings);
    assign tx_used  = r_txw[q] - r_txr[q];
    assign rx_pend  = r_rxw[q] - r_rxr[q];
    assign rx_since = r_rxw[r_oring] - r_rxr[r_oring];
    assign room     = {1'b0, tx_used} + 33'(r_item.length);

    logic [12:0] left_m1;
    assign left_m1 = r_left - 13'd1;

    logic send_open, recv_open;

    // Result of the beat under evaluation and whether it opens a transfer.
    always_comb begin
        n_res     = '0;
        send_open = 1'b0;
        recv_open = 1'b0;
        case (r_item.op)
            mrmf_pkg::OP_SEND_BEGIN: begin
                if (bad) n_res.status = mrmf_pkg::ST_BADRING;
                else if (r_item.length > 13'(tsz)) n_res.status = mrmf_pkg::ST_LONG;
                else if (room > 33'(tsz)) n_res.status = mrmf_pkg::ST_ROOM;
                else if (r_item.length == 13'd0) begin
                    n_res.last        = 1'b1;
                    n_res.write_event = 1'b1;
                end else begin
                    send_open = 1'b1;
                end
            end
            mrmf_pkg::OP_SEND_BYTE: begin
                if (r_mode != M_SEND) n_res.status = mrmf_pkg::ST_NOXFER;
                else if (left_m1 == 13'd0) begin
                    n_res.last        = 1'b1;
                    n_res.write_event = 1'b1;
                end
            end
            mrmf_pkg::OP_RECV_BEGIN: begin
                if (bad) n_res.status = mrmf_pkg::ST_BADRING;
                else if (rx_pend == 32'd0) n_res.status = mrmf_pkg::ST_EMPTY;
                else if (rx_pend > 32'(rsz)) begin
                    n_res.status     = mrmf_pkg::ST_OVERRUN;
                    n_res.read_event = 1'b1;
                end else begin
                    n_res.count = rx_pend[12:0];
                    recv_open   = 1'b1;
                end
            end
            mrmf_pkg::OP_RECV_BYTE: begin
                if (r_mode != M_RECV) n_res.status = mrmf_pkg::ST_NOXFER;
                else begin
                    n_res.byte_out = r_rx_rd;
                    if (left_m1 == 13'd0) begin
                        n_res.last       = 1'b1;
                        n_res.read_event = (rx_since >= 32'(rsz));
                    end
                end
            end
            mrmf_pkg::OP_PEER_PUT: begin
                if (bad) n_res.status = mrmf_pkg::ST_BADRING;
            end
            mrmf_pkg::OP_PEER_GET: begin
                if (bad) n_res.status = mrmf_pkg::ST_BADRING;
                else if (tx_used == 32'd0) n_res.status = mrmf_pkg::ST_EMPTY;
                else n_res.byte_out = r_tx_rd;
            end
            mrmf_pkg::OP_POLL: begin
                if (bad) n_res.status = mrmf_pkg::ST_BADRING;
                else n_res.writable = (tx_used < 32'(tsz));
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.eval) begin
            if (r_item.op == mrmf_pkg::OP_SEND_BYTE && r_mode == M_SEND) begin
                tx_mem[{r_oring, r_cursor}] <= r_item.data;
            end
            if (r_item.op == mrmf_pkg::OP_PEER_PUT && !bad) begin
                rx_mem[{q, r_rxwo[q]}] <= r_item.data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx_size   <= 13'd4096;
            r_rx_size   <= 13'd4096;
            r_num_rings <= 4'd1;
            r_mode      <= M_NONE;
            r_oring     <= '0;
            r_left      <= '0;
            r_cursor    <= '0;
            r_total     <= '0;
            for (int i = 0; i < NR; i++) begin
                r_txw[i] <= '0; r_txr[i] <= '0; r_rxw[i] <= '0; r_rxr[i] <= '0;
                r_txwo[i] <= '0; r_txro[i] <= '0; r_rxwo[i] <= '0; r_rxro[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    mrmf_pkg::REG_TX_SIZE:   r_tx_size   <= i_cfg_data;
                    mrmf_pkg::REG_RX_SIZE:   r_rx_size   <= i_cfg_data;
                    mrmf_pkg::REG_NUM_RINGS: r_num_rings <= i_cfg_data[3:0];
                    default: ;
                endcase
            end
            if (i_cmd.eval) begin
                r_res <= n_res;
                case (r_item.op)
                    mrmf_pkg::OP_SEND_BEGIN: begin
                        if (send_open) begin
                            r_mode   <= M_SEND;
                            r_oring  <= q;
                            r_left   <= r_item.length;
                            r_total  <= r_item.length;
                            r_cursor <= r_txwo[q];
                        end else begin
                            r_mode <= M_NONE;
                        end
                    end
                    mrmf_pkg::OP_SEND_BYTE: begin
                        if (r_mode == M_SEND) begin
                            r_cursor <= adv(r_cursor, tsz);
                            r_left   <= left_m1;
                            if (left_m1 == 13'd0) begin
                                r_txw[r_oring]  <= r_txw[r_oring] + 32'(r_total);
                                r_txwo[r_oring] <= adv(r_cursor, tsz);
                                r_mode <= M_NONE;
                            end
                        end
                    end
                    mrmf_pkg::OP_RECV_BEGIN: begin
                        if (recv_open) begin
                            r_mode   <= M_RECV;
                            r_oring  <= q;
                            r_left   <= rx_pend[12:0];
                            r_total  <= rx_pend[12:0];
                            r_cursor <= r_rxro[q];
                        end else begin
                            r_mode <= M_NONE;
                            if (n_res.status == mrmf_pkg::ST_OVERRUN) begin
                                r_rxr[q]  <= r_rxw[q];
                                r_rxro[q] <= r_rxwo[q];
                            end
                        end
                    end
                    mrmf_pkg::OP_RECV_BYTE: begin
                        if (r_mode == M_RECV) begin
                            r_cursor <= adv(r_cursor, rsz);
                            r_left   <= left_m1;
                            if (left_m1 == 13'd0) begin
                                r_rxr[r_oring]  <= r_rxr[r_oring] + 32'(r_total);
                                r_rxro[r_oring] <= adv(r_cursor, rsz);
                                r_mode <= M_NONE;
                            end
                        end
                    end
                    mrmf_pkg::OP_PEER_PUT: begin
                        if (!bad) begin
                            r_rxwo[q] <= adv(r_rxwo[q], rsz);
                            r_rxw[q]  <= r_rxw[q] + 32'd1;
                        end
                    end
                    mrmf_pkg::OP_PEER_GET: begin
                        if (!bad && tx_used != 32'd0) begin
                            r_txro[q] <= adv(r_txro[q], tsz);
                            r_txr[q]  <= r_txr[q] + 32'd1;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    assign o_result = r_res;
endmodule

FILE: tb/sv/ring_fifo_checker.sv
`timescale 1ns / 1ps
module ring_fifo_checker
    import mrmf_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [12:0]         i_cfg_data,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  t_in                 i_in_data,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  t_out                i_out_data,
    output int                  o_fail,
    output int                  o_pending,
    output logic [7:0][31:0]    o_tx_used,
    output logic [7:0][31:0]    o_rx_pend
);
    localparam logic [1:0] XFER_NONE = 2'd0;
    localparam logic [1:0] XFER_SEND = 2'd1;
    localparam logic [1:0] XFER_RECV = 2'd2;

    logic [12:0] tx_size_reg, rx_size_reg;
    logic [3:0]  ring_count_reg;
    logic [7:0]  tx_mem [MAX_RINGS*RING_BYTES];
    logic [7:0]  rx_mem [MAX_RINGS*RING_BYTES];
    logic [31:0] tx_wp [MAX_RINGS], tx_rp [MAX_RINGS];
    logic [31:0] rx_wp [MAX_RINGS], rx_rp [MAX_RINGS];
    int          tx_wo [MAX_RINGS], tx_ro [MAX_RINGS];
    int          rx_wo [MAX_RINGS], rx_ro [MAX_RINGS];
    logic [1:0]  xfer_mode;
    int          xfer_ring, xfer_left, xfer_pos, xfer_total;
    t_out        expected_results [$];
    int          fail_count;

    assign o_fail    = fail_count;
    assign o_pending = expected_results.size();

    always_comb begin
        for (int r = 0; r < MAX_RINGS; r++) begin
            o_tx_used[r] = tx_wp[r] - tx_rp[r];
            o_rx_pend[r] = rx_wp[r] - rx_rp[r];
        end
    end

    function automatic int eff_size(logic [12:0] s);
        if (s == 0) return 1;
        if (s > RING_BYTES) return RING_BYTES;
        return int'(s);
    endfunction

    function automatic int step_offset(int off, int size);
        return (off + 1 >= size) ? 0 : off + 1;
    endfunction

    function automatic t_out predict_result(t_in it);
        t_out        res;
        int          tsz, rsz, rings, r;
        logic [31:0] used, oldpos;
        logic        ring_op;
        res = '0;
        tsz = eff_size(tx_size_reg);
        rsz = eff_size(rx_size_reg);
        rings = (ring_count_reg == 0) ? 1 : (ring_count_reg > MAX_RINGS) ? MAX_RINGS
                : int'(ring_count_reg);
        r = int'(it.ring);
        ring_op = (it.op == OP_SEND_BEGIN) || (it.op == OP_RECV_BEGIN) ||
                  (it.op == OP_PEER_PUT) || (it.op == OP_PEER_GET) || (it.op == OP_POLL);
        if (ring_op && r >= rings) begin
            res.status = ST_BADRING;
            if (it.op == OP_SEND_BEGIN || it.op == OP_RECV_BEGIN) xfer_mode = XFER_NONE;
        end else begin
            case (it.op)
                OP_SEND_BEGIN: begin
                    used = tx_wp[r] - tx_rp[r];
                    xfer_mode = XFER_NONE;
                    if (it.length > tsz) begin
                        res.status = ST_LONG;
                    end else if (64'(used) + 64'(it.length) > 64'(tsz)) begin
                        res.status = ST_ROOM;
                    end else if (it.length == 0) begin
                        res.last = 1'b1;
                        res.write_event = 1'b1;
                    end else begin
                        xfer_mode = XFER_SEND;
                        xfer_ring = r;
                        xfer_left = int'(it.length);
                        xfer_total = int'(it.length);
                        xfer_pos = tx_wo[r];
                    end
                end
                OP_SEND_BYTE: begin
                    if (xfer_mode != XFER_SEND) begin
                        res.status = ST_NOXFER;
                    end else begin
                        tx_mem[xfer_ring*RING_BYTES + xfer_pos] = it.data;
                        xfer_pos = step_offset(xfer_pos, tsz);
                        xfer_left--;
                        if (xfer_left == 0) begin
                            tx_wp[xfer_ring] += 32'(xfer_total);
                            tx_wo[xfer_ring] = xfer_pos;
                            xfer_mode = XFER_NONE;
                            res.last = 1'b1;
                            res.write_event = 1'b1;
                        end
                    end
                end
                OP_RECV_BEGIN: begin
                    used = rx_wp[r] - rx_rp[r];
                    xfer_mode = XFER_NONE;
                    if (used == 0) begin
                        res.status = ST_EMPTY;
                    end else if (used > 32'(rsz)) begin
                        // Overrun: drop everything pending and resync to the writer.
                        rx_rp[r] = rx_wp[r];
                        rx_ro[r] = rx_wo[r];
                        res.status = ST_OVERRUN;
                        res.read_event = 1'b1;
                    end else begin
                        res.count = 13'(used);
                        xfer_mode = XFER_RECV;
                        xfer_ring = r;
                        xfer_left = int'(used);
                        xfer_total = int'(used);
                        xfer_pos = rx_ro[r];
                    end
                end
                OP_RECV_BYTE: begin
                    if (xfer_mode != XFER_RECV) begin
                        res.status = ST_NOXFER;
                    end else begin
                        res.byte_out = rx_mem[xfer_ring*RING_BYTES + xfer_pos];
                        xfer_pos = step_offset(xfer_pos, rsz);
                        xfer_left--;
                        if (xfer_left == 0) begin
                            oldpos = rx_rp[xfer_ring];
                            rx_rp[xfer_ring] = oldpos + 32'(xfer_total);
                            rx_ro[xfer_ring] = xfer_pos;
                            xfer_mode = XFER_NONE;
                            res.last = 1'b1;
                            if (rx_wp[xfer_ring] - oldpos >= 32'(rsz)) res.read_event = 1'b1;
                        end
                    end
                end
                OP_PEER_PUT: begin
                    rx_mem[r*RING_BYTES + rx_wo[r]] = it.data;
                    rx_wo[r] = step_offset(rx_wo[r], rsz);
                    rx_wp[r] += 1;
                end
                OP_PEER_GET: begin
                    if (tx_wp[r] == tx_rp[r]) begin
                        res.status = ST_EMPTY;
                    end else begin
                        res.byte_out = tx_mem[r*RING_BYTES + tx_ro[r]];
                        tx_ro[r] = step_offset(tx_ro[r], tsz);
                        tx_rp[r] += 1;
                    end
                end
                OP_POLL: res.writable = (tx_wp[r] - tx_rp[r]) < 32'(tsz);
                default: ;
            endcase
        end
        return res;
    endfunction

    task automatic report_field(string name, int want, int got);
        $display("%0t: mismatch in %s: expected %0d, got %0d", $time, name, want, got);
        fail_count++;
    endtask

    initial begin
        fail_count = 0;
        xfer_mode = XFER_NONE;
        for (int r = 0; r < MAX_RINGS; r++) begin
            tx_wp[r] = 0; tx_rp[r] = 0; rx_wp[r] = 0; rx_rp[r] = 0;
            tx_wo[r] = 0; tx_ro[r] = 0; rx_wo[r] = 0; rx_ro[r] = 0;
        end
    end

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            tx_size_reg = 13'd4096;
            rx_size_reg = 13'd4096;
            ring_count_reg = 4'd1;
            xfer_mode = XFER_NONE;
            xfer_ring = 0; xfer_left = 0; xfer_pos = 0; xfer_total = 0;
            for (int r = 0; r < MAX_RINGS; r++) begin
                tx_wp[r] = 0; tx_rp[r] = 0; rx_wp[r] = 0; rx_rp[r] = 0;
                tx_wo[r] = 0; tx_ro[r] = 0; rx_wo[r] = 0; rx_ro[r] = 0;
            end
            expected_results.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_TX_SIZE:   tx_size_reg = i_cfg_data;
                    REG_RX_SIZE:   rx_size_reg = i_cfg_data;
                    REG_NUM_RINGS: ring_count_reg = i_cfg_data[3:0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result beat %h", $time, i_out_data);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (i_out_data.status !== want.status)
                        report_field("status", want.status, i_out_data.status);
                    if (i_out_data.byte_out !== want.byte_out)
                        report_field("byte_out", want.byte_out, i_out_data.byte_out);
                    if (i_out_data.count !== want.count)
                        report_field("count", want.count, i_out_data.count);
                    if (i_out_data.last !== want.last)
                        report_field("last", want.last, i_out_data.last);
                    if (i_out_data.write_event !== want.write_event)
                        report_field("write_event", want.write_event, i_out_data.write_event);
                    if (i_out_data.read_event !== want.read_event)
                        report_field("read_event", want.read_event, i_out_data.read_event);
                    if (i_out_data.writable !== want.writable)
                        report_field("writable", want.writable, i_out_data.writable);
                end
            end
            if (i_in_valid && i_in_ready) expected_results.push_back(predict_result(i_in_data));
        end
    end
endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
module testbench;
    import mrmf_pkg::*;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [1:0]        i_cfg_index = REG_TX_SIZE;
    logic [12:0]       i_cfg_data = '0;
    logic              i_in_valid = 1'b0;
    logic              o_in_ready;
    t_in               i_in_data = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    t_out              o_out_data;
    int                fail_count, pending;
    logic [7:0][31:0]  tx_used, rx_pend;

    logic  idling = 1'b1;
    logic  hold_req = 1'b0;
    int    beats_sent = 0;
    int    phases_done = 0;
    int    cur_tx = 4096;
    int    cur_rings = 1;

    always #5 i_clk = ~i_clk;

    multi_ring_message_fifo u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data)
    );

    ring_fifo_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .i_in_ready(o_in_ready), .i_in_data(i_in_data),
        .i_out_valid(o_out_valid), .i_out_ready(i_out_ready), .i_out_data(o_out_data),
        .o_fail(fail_count), .o_pending(pending),
        .o_tx_used(tx_used), .o_rx_pend(rx_pend)
    );

    // Result side: random stall bursts, plus one long hold-off on request.
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_out_ready <= 1'b0;
                repeat (80) @(negedge i_clk);
                hold_req = 1'b0;
                i_out_ready <= 1'b1;
            end else if (idling && $urandom_range(0, 7) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge i_clk);
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    initial begin
        #10ms;
        $display("simulation failed");
        $finish;
    end

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic offer(t_in it);
        if (idling && $urandom_range(0, 9) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= it;
        do @(posedge i_clk); while (!o_in_ready);
        beats_sent++;
        @(negedge i_clk);
    endtask

    task automatic issue(logic [2:0] op, int ring, int len, int data);
        t_in it;
        it.op = op;
        it.ring = 3'(ring);
        it.length = 13'(len);
        it.data = 8'(data);
        offer(it);
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, int value);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= 13'(value);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Empty every ring so no later read can land on storage never written
    // under the new ring sizes.
    task automatic drain_all();
        int n;
        settle();
        write_reg(REG_NUM_RINGS, 8);
        for (int r = 0; r < MAX_RINGS; r++) begin
            while (tx_used[r] != 0) issue(OP_PEER_GET, r, 0, 0);
            if (rx_pend[r] != 0) begin
                issue(OP_RECV_BEGIN, r, 0, 0);
                n = rx_pend[r];
                repeat (n) issue(OP_RECV_BYTE, 0, 0, 0);
            end
        end
        // A send begin that is too long closes any send left open.
        issue(OP_SEND_BEGIN, 0, 8191, 0);
        settle();
    endtask

    task automatic run_message();
        int r, len, nbytes, n;
        r = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 7) : $urandom_range(0, cur_rings - 1);
        case ($urandom_range(0, 5))
            0: begin
                len = $urandom_range(0, 7) == 0 ? $urandom_range(0, 8191)
                                                : $urandom_range(0, cur_tx + 1);
                issue(OP_SEND_BEGIN, r, len, $urandom_range(0, 255));
                nbytes = (len <= 24) ? len : $urandom_range(0, 24);
                if ($urandom_range(0, 9) == 0 && nbytes > 0) nbytes--;
                repeat (nbytes) issue(OP_SEND_BYTE, $urandom_range(0, 7),
                                      $urandom_range(0, 8191), $urandom_range(0, 255));
            end
            1: begin
                len = $urandom_range(0, (cur_tx < 12) ? cur_tx : 12);
                issue(OP_SEND_BEGIN, r, len, 0);
                repeat (len) issue(OP_SEND_BYTE, 0, 0, $urandom_range(0, 255));
            end
            2: begin
                issue(OP_RECV_BEGIN, r, $urandom_range(0, 8191), 0);
                n = (r < cur_rings) ? rx_pend[r] : 0;
                if ($urandom_range(0, 9) == 0 && n > 0) n = $urandom_range(0, n - 1);
                repeat (n) issue(OP_RECV_BYTE, $urandom_range(0, 7), 0, 0);
            end
            3: repeat ($urandom_range(1, 8)) issue(OP_PEER_PUT, r, 0, $urandom_range(0, 255));
            4: begin
                repeat ($urandom_range(1, 6)) issue(OP_PEER_GET, r, 0, 0);
                issue(OP_POLL, r, 0, 0);
            end
            default: issue(3'($urandom_range(0, 7)), $urandom_range(0, 7),
                           $urandom_range(0, 8191), $urandom_range(0, 255));
        endcase
    endtask

    initial begin
        int phase_tx [6] = '{16, 1, 4096, 0, 5, 12};
        int phase_rx [6] = '{8, 1, 4096, 8191, 3, 16};
        int phase_rn [6] = '{4, 8, 8, 0, 15, 2};
        int target;

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part under reset settings: one ring of 4096 bytes each way.
        issue(OP_POLL, 0, 0, 0);
        issue(OP_PEER_GET, 0, 0, 0);
        issue(OP_RECV_BEGIN, 0, 0, 0);
        issue(OP_SEND_BYTE, 0, 0, 8'hff);
        issue(OP_RECV_BYTE, 0, 0, 0);
        issue(OP_SEND_BEGIN, 7, 1, 0);
        issue(OP_PEER_PUT, 1, 0, 8'h5a);
        issue(OP_SEND_BEGIN, 0, 0, 0);
        issue(OP_SEND_BEGIN, 0, 4097, 0);
        issue(OP_SEND_BEGIN, 0, 8191, 0);
        issue(OP_SEND_BEGIN, 0, 3, 0);
        issue(OP_SEND_BYTE, 0, 0, 8'hff);
        issue(OP_SEND_BEGIN, 0, 2, 0);
        issue(OP_SEND_BYTE, 0, 0, 8'h00);
        issue(OP_SEND_BYTE, 0, 0, 8'ha5);
        issue(OP_PEER_GET, 0, 0, 0);
        issue(OP_PEER_GET, 0, 0, 0);
        issue(OP_PEER_PUT, 0, 0, 8'hff);
        issue(OP_PEER_PUT, 0, 0, 8'h00);
        issue(OP_RECV_BEGIN, 0, 0, 0);
        issue(OP_RECV_BYTE, 0, 0, 0);
        issue(OP_RECV_BYTE, 0, 0, 0);
        issue(3'd7, 7, 8191, 8'hff);

        for (int p = 0; p < 6; p++) begin
            drain_all();
            write_reg(REG_TX_SIZE, phase_tx[p]);
            write_reg(REG_RX_SIZE, phase_rx[p]);
            write_reg(REG_NUM_RINGS, phase_rn[p]);
            cur_tx = (phase_tx[p] == 0) ? 1 : (phase_tx[p] > RING_BYTES) ? RING_BYTES
                     : phase_tx[p];
            cur_rings = (phase_rn[p] == 0) ? 1 : (phase_rn[p] > MAX_RINGS) ? MAX_RINGS
                        : phase_rn[p];
            if (p == 5) idling = 1'b0;
            // The receiver holds off for a long stretch early in this phase.
            if (p == 1) hold_req = 1'b1;
            target = beats_sent + 150;
            while (beats_sent < target) begin
                run_message();
            end
            phases_done++;
        end

        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
        $display("Covered %0d beats over %0d ring settings after the directed checks,",
                 beats_sent, phases_done);
        $display("including message sends, receives, overruns and peer traffic.");
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

FILE: filelist.f
design/mrmf_pkg.sv
design/mrmf_ctrl.sv
design/mrmf_dp.sv
design/multi_ring_message_fifo.sv
tb/sv/ring_fifo_checker.sv
tb/sv/testbench.sv
